// ----- hw/rtl/fsrd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsrd_pkg
// shared types, constants and the mod-3 frame step for the frame shift
// range detector
// ----------------------------------------------------------------------------
package fsrd_pkg;

   // default column index width
   localparam int POS_WIDTH_DEFAULT = 16;

   // reading frame, always 0, 1 or 2
   typedef logic [1:0] frame_type;

   localparam frame_type FRAME_ZERO = 2'd0;
   // insertion moves the frame by -1, which is +2 modulo 3
   localparam frame_type STEP_INSERTION = 2'd2;
   localparam frame_type STEP_DELETION = 2'd1;
   localparam logic [2:0] FRAME_MODULUS = 3'd3;

   // flags of one result transaction
   typedef struct packed {
      logic range_valid;
      logic last;
   } rsp_flags_type;

   // frame plus step, modulo 3; both operands stay below 3
   function automatic frame_type frame_step(frame_type frame, frame_type step);
      logic [2:0] sum;
      sum = {1'b0, frame} + {1'b0, step};
      if (sum >= FRAME_MODULUS) begin
         sum = sum - FRAME_MODULUS;
      end
      return sum[1:0];
   endfunction

endpackage

// ----- hw/rtl/fsrd_if.sv -----
// ----------------------------------------------------------------------------
// fsrd_req_if / fsrd_rsp_if
// valid/ready channels carrying alignment columns in and detected ranges out
// ----------------------------------------------------------------------------
interface fsrd_req_if #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [POS_WIDTH-1:0] position;
   logic                 ref_gap;
   logic                 query_gap;
   logic                 end_of_sequence;

   modport source (output valid, position, ref_gap, query_gap, end_of_sequence,
                   input ready);
   modport sink (input valid, position, ref_gap, query_gap, end_of_sequence,
                 output ready);
endinterface

interface fsrd_rsp_if #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [POS_WIDTH-1:0] range_begin;
   logic [POS_WIDTH-1:0] range_end;
   logic                 range_valid;
   logic                 last;

   modport source (output valid, range_begin, range_end, range_valid, last,
                   input ready);
   modport sink (input valid, range_begin, range_end, range_valid, last,
                 output ready);
endinterface

// ----- hw/rtl/frame_shift_range_detector.sv -----
// ----------------------------------------------------------------------------
// frame_shift_range_detector
// tracks the reading frame over alignment columns and reports the ranges in
// which the query frame is shifted
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake                fields
//  req_chan   in   valid/ready              position, ref_gap, query_gap,
//                                           end_of_sequence
//  rsp_chan   out  valid/ready              range_begin, range_end,
//                                           range_valid, last
//
//  one column per cycle while the result register has room: the state
//  update and result are computed as the column is taken, the result shows in
//  the cycle after; columns yield zero or one, an end transaction always one
//  synchronous reset clears the frame state and the result valid
//  while a result waits unread the next column is still taken as long as
//  the waiting result is read in that same cycle
//
module frame_shift_range_detector #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   fsrd_req_if.sink   req_chan,
   fsrd_rsp_if.source rsp_chan
);

   logic                    accept;
   logic                    in_ready;
   logic                    result_present;
   logic [POS_WIDTH-1:0]    result_begin;
   logic [POS_WIDTH-1:0]    result_end;
   fsrd_pkg::rsp_flags_type result_flags;
   fsrd_pkg::rsp_flags_type out_flags;

   // a column transaction moves when the result register has room
   assign req_chan.ready = in_ready;
   assign accept = req_chan.valid && in_ready;

   // frame state and update logic
   fsrd_core #(
      .POS_WIDTH(POS_WIDTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .position        (req_chan.position),
      .ref_gap         (req_chan.ref_gap),
      .query_gap       (req_chan.query_gap),
      .end_of_sequence (req_chan.end_of_sequence),
      .result_present  (result_present),
      .result_begin    (result_begin),
      .result_end      (result_end),
      .result_flags    (result_flags)
   );

   // result register toward the response channel
   fsrd_out_reg #(
      .POS_WIDTH(POS_WIDTH)
   ) u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .result_present (result_present),
      .result_begin   (result_begin),
      .result_end     (result_end),
      .result_flags   (result_flags),
      .out_ready      (rsp_chan.ready),
      .in_ready       (in_ready),
      .out_valid      (rsp_chan.valid),
      .out_begin      (rsp_chan.range_begin),
      .out_end        (rsp_chan.range_end),
      .out_flags      (out_flags)
   );

   assign rsp_chan.range_valid = out_flags.range_valid;
   assign rsp_chan.last = out_flags.last;

endmodule

// ----- hw/rtl/fsrd_core.sv -----
// ----------------------------------------------------------------------------
// fsrd_core
// frame tracking state and the per-column update; produces at most one
// result per accepted transaction
// ----------------------------------------------------------------------------
module fsrd_core #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [POS_WIDTH-1:0]    position,
   input  logic                    ref_gap,
   input  logic                    query_gap,
   input  logic                    end_of_sequence,
   output logic                    result_present,
   output logic [POS_WIDTH-1:0]    result_begin,
   output logic [POS_WIDTH-1:0]    result_end,
   output fsrd_pkg::rsp_flags_type result_flags
);

   fsrd_pkg::frame_type  current_frame_ff, current_frame_in;
   fsrd_pkg::frame_type  previous_frame_ff, previous_frame_in;
   logic [POS_WIDTH-1:0] range_start_ff, range_start_in;
   logic                 range_start_set_ff, range_start_set_in;
   logic [POS_WIDTH-1:0] range_stop_ff, range_stop_in;
   logic [POS_WIDTH-1:0] indel_pos_ff, indel_pos_in;
   logic                 indel_pos_set_ff, indel_pos_set_in;
   logic                 recheck_pending_ff, recheck_pending_in;

   fsrd_pkg::frame_type  step;
   fsrd_pkg::frame_type  frame_after;
   logic [POS_WIDTH:0]   indel_next;
   logic                 adjacent;

   // adjacency without wrap: the top column is never followed by column 0
   assign indel_next = {1'b0, indel_pos_ff} + {{POS_WIDTH{1'b0}}, 1'b1};
   assign adjacent = indel_pos_set_ff && (indel_next == {1'b0, position});
   assign step = ref_gap ? fsrd_pkg::STEP_INSERTION : fsrd_pkg::STEP_DELETION;
   assign frame_after = fsrd_pkg::frame_step(current_frame_ff, step);

   always_comb begin
      current_frame_in = current_frame_ff;
      previous_frame_in = previous_frame_ff;
      range_start_in = range_start_ff;
      range_start_set_in = range_start_set_ff;
      range_stop_in = range_stop_ff;
      indel_pos_in = indel_pos_ff;
      indel_pos_set_in = indel_pos_set_ff;
      recheck_pending_in = recheck_pending_ff;
      result_present = 1'b0;
      result_begin = '0;
      result_end = '0;
      result_flags = '0;

      if (end_of_sequence) begin
         // flush and return to reset state
         result_present = 1'b1;
         result_flags.last = 1'b1;
         result_flags.range_valid = range_start_set_ff;
         if (range_start_set_ff) begin
            result_begin = range_start_ff;
            result_end = position;
         end
         current_frame_in = fsrd_pkg::FRAME_ZERO;
         previous_frame_in = fsrd_pkg::FRAME_ZERO;
         range_start_in = '0;
         range_start_set_in = 1'b0;
         range_stop_in = '0;
         indel_pos_in = '0;
         indel_pos_set_in = 1'b0;
         recheck_pending_in = 1'b0;
      end else if (ref_gap || query_gap) begin
         previous_frame_in = current_frame_ff;
         current_frame_in = frame_after;
         if (!adjacent) begin
            range_stop_in = position;
         end
         if ((current_frame_ff == fsrd_pkg::FRAME_ZERO) !=
             (frame_after == fsrd_pkg::FRAME_ZERO)) begin
            recheck_pending_in = 1'b1;
         end
         indel_pos_in = position;
         indel_pos_set_in = 1'b1;
      end else if (recheck_pending_ff) begin
         if (current_frame_ff == fsrd_pkg::FRAME_ZERO && range_start_set_ff) begin
            result_present = 1'b1;
            result_flags.range_valid = 1'b1;
            result_begin = range_start_ff;
            result_end = range_stop_ff;
            range_start_in = '0;
            range_start_set_in = 1'b0;
            range_stop_in = '0;
            indel_pos_in = '0;
            indel_pos_set_in = 1'b0;
         end
         if (current_frame_ff != fsrd_pkg::FRAME_ZERO && !range_start_set_ff) begin
            range_start_in = position;
            range_start_set_in = 1'b1;
         end
         recheck_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_frame_ff <= fsrd_pkg::FRAME_ZERO;
         previous_frame_ff <= fsrd_pkg::FRAME_ZERO;
         range_start_ff <= '0;
         range_start_set_ff <= 1'b0;
         range_stop_ff <= '0;
         indel_pos_ff <= '0;
         indel_pos_set_ff <= 1'b0;
         recheck_pending_ff <= 1'b0;
      end else if (accept) begin
         current_frame_ff <= current_frame_in;
         previous_frame_ff <= previous_frame_in;
         range_start_ff <= range_start_in;
         range_start_set_ff <= range_start_set_in;
         range_stop_ff <= range_stop_in;
         indel_pos_ff <= indel_pos_in;
         indel_pos_set_ff <= indel_pos_set_in;
         recheck_pending_ff <= recheck_pending_in;
      end
   end

endmodule

// ----- hw/rtl/fsrd_out_reg.sv -----
// ----------------------------------------------------------------------------
// fsrd_out_reg
// result register; frees the input side whenever the held result is taken
// ----------------------------------------------------------------------------
module fsrd_out_reg #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    result_present,
   input  logic [POS_WIDTH-1:0]    result_begin,
   input  logic [POS_WIDTH-1:0]    result_end,
   input  fsrd_pkg::rsp_flags_type result_flags,
   input  logic                    out_ready,
   output logic                    in_ready,
   output logic                    out_valid,
   output logic [POS_WIDTH-1:0]    out_begin,
   output logic [POS_WIDTH-1:0]    out_end,
   output fsrd_pkg::rsp_flags_type out_flags
);

   logic                    valid_ff, valid_in;
   logic [POS_WIDTH-1:0]    begin_ff;
   logic [POS_WIDTH-1:0]    end_ff;
   fsrd_pkg::rsp_flags_type flags_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = result_present;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result_present) begin
         begin_ff <= result_begin;
         end_ff <= result_end;
         flags_ff <= result_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_begin = begin_ff;
   assign out_end = end_ff;
   assign out_flags = flags_ff;

endmodule

// ----- hw/rtl/fsrd_checker.sv -----
// ----------------------------------------------------------------------------
// fsrd_checker
// port-level checks on the frame shift range detector, bound to the top level
// ----------------------------------------------------------------------------
module fsrd_checker #(
   parameter int POS_WIDTH = fsrd_pkg::POS_WIDTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_ref_gap,
   input logic                 req_query_gap,
   input logic                 req_end_of_sequence,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [POS_WIDTH-1:0] rsp_range_begin,
   input logic [POS_WIDTH-1:0] rsp_range_end,
   input logic                 rsp_range_valid,
   input logic                 rsp_last
);

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_begin) &&
      $stable(rsp_range_end) && $stable(rsp_range_valid) && $stable(rsp_last))
      else $error("stalled result changed");

   // an end transaction is answered in the next cycle with a last result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_sequence |=> rsp_valid && rsp_last)
      else $error("end transaction not answered with last");

   // a gap column never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_end_of_sequence &&
      (req_ref_gap || req_query_gap) |=> !rsp_valid)
      else $error("gap column produced a result");

   // only the end result may come without a range, and then it is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_valid |->
      rsp_last && rsp_range_begin == '0 && rsp_range_end == '0)
      else $error("empty result not a zero last result");

   // a held result that is not read blocks new columns
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("column taken while result register full");

endmodule

bind frame_shift_range_detector fsrd_checker #(
   .POS_WIDTH(POS_WIDTH)
) u_fsrd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_ref_gap         (req_chan.ref_gap),
   .req_query_gap       (req_chan.query_gap),
   .req_end_of_sequence (req_chan.end_of_sequence),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_range_begin     (rsp_chan.range_begin),
   .rsp_range_end       (rsp_chan.range_end),
   .rsp_range_valid     (rsp_chan.range_valid),
   .rsp_last            (rsp_chan.last)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame shift range detector: alignment columns
// go in over the request channel, a frame tracker in the bench predicts each
// reported range and every response transaction is compared against it
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW = fsrd_pkg::POS_WIDTH_DEFAULT;
   // frames live modulo this count
   localparam int FRAME_COUNT = 3;
   // cycles to idle after the last expected range before the verdict
   localparam int TAIL_CYCLES = 10;
   // generous wall for the whole run, in ns
   localparam int RUN_LIMIT_NS = 3_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int IDLE_PERCENT = 33;

   typedef logic [PW-1:0] pos_type;

   typedef struct packed {
      pos_type range_begin;
      pos_type range_end;
      logic    range_valid;
      logic    last;
   } range_result_type;

   logic clock;
   logic reset;

   fsrd_req_if #(.POS_WIDTH(PW)) req_bus ();
   fsrd_rsp_if #(.POS_WIDTH(PW)) rsp_bus ();

   frame_shift_range_detector #(.POS_WIDTH(PW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ranges the tracker predicts, oldest first
   range_result_type expected_ranges[$];
   int check_failures = 0;
   // both sides of the bench idle at random while this is set
   bit idle_enabled = 1'b1;

   // bench copy of the frame tracking state
   fsrd_pkg::frame_type tracked_frame;
   fsrd_pkg::frame_type frame_before_indel;
   pos_type   open_begin;
   logic      open_begin_set;
   pos_type   open_stop;
   pos_type   last_indel_pos;
   logic      last_indel_set;
   logic      recheck_frame;

   // ---------------------------------------------------------------------
   // frame tracker
   // ---------------------------------------------------------------------

   function automatic void clear_frame_state();
      tracked_frame      = fsrd_pkg::FRAME_ZERO;
      frame_before_indel = fsrd_pkg::FRAME_ZERO;
      open_begin         = '0;
      open_begin_set     = 1'b0;
      open_stop          = '0;
      last_indel_pos     = '0;
      last_indel_set     = 1'b0;
      recheck_frame      = 1'b0;
   endfunction

   function automatic void record_indel(fsrd_pkg::frame_type step, pos_type pos);
      logic adjacent;
      frame_before_indel = tracked_frame;
      tracked_frame = fsrd_pkg::frame_type'((int'(tracked_frame) + int'(step))
                                            % FRAME_COUNT);
      // adjacency is checked one bit wider so the top column never wraps to 0,
      // and an unset last indel is never adjacent
      adjacent = last_indel_set && ({1'b0, pos} == {1'b0, last_indel_pos} + 1'b1);
      if (!adjacent) begin
         open_stop = pos;
      end
      // leaving frame 0 or coming back to it needs a look at the next plain column
      if ((frame_before_indel == fsrd_pkg::FRAME_ZERO) !=
          (tracked_frame == fsrd_pkg::FRAME_ZERO)) begin
         recheck_frame = 1'b1;
      end
      last_indel_pos = pos;
      last_indel_set = 1'b1;
   endfunction

   // advances the tracker by one column, returns 1 when a result is due
   function automatic bit track_column(pos_type pos, logic rgap, logic qgap, logic eos,
                                       output range_result_type result);
      bit found;
      found  = 1'b0;
      result = '0;
      if (eos) begin
         // the end transaction closes an open range at the sequence length
         result.last = 1'b1;
         if (open_begin_set) begin
            result.range_begin = open_begin;
            result.range_end   = pos;
            result.range_valid = 1'b1;
         end
         clear_frame_state();
         return 1'b1;
      end
      if (rgap) begin
         record_indel(fsrd_pkg::STEP_INSERTION, pos);
         return 1'b0;
      end
      if (qgap) begin
         record_indel(fsrd_pkg::STEP_DELETION, pos);
         return 1'b0;
      end
      if (!recheck_frame) begin
         return 1'b0;
      end
      if (tracked_frame == fsrd_pkg::FRAME_ZERO && open_begin_set) begin
         // frame back in step: report the open range
         result.range_begin = open_begin;
         result.range_end   = open_stop;
         result.range_valid = 1'b1;
         found = 1'b1;
         open_begin     = '0;
         open_begin_set = 1'b0;
         open_stop      = '0;
         last_indel_pos = '0;
         last_indel_set = 1'b0;
      end
      if (tracked_frame != fsrd_pkg::FRAME_ZERO && !open_begin_set) begin
         open_begin     = pos;
         open_begin_set = 1'b1;
      end
      recheck_frame = 1'b0;
      return found;
   endfunction

   // ---------------------------------------------------------------------
   // clock, reset and run limit
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // monitors
   // ---------------------------------------------------------------------

   // every accepted column transaction goes through the tracker
   always @(posedge clock) begin : column_monitor
      range_result_type predicted;
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (track_column(req_bus.position, req_bus.ref_gap, req_bus.query_gap,
                          req_bus.end_of_sequence, predicted)) begin
            expected_ranges = {expected_ranges, predicted};
         end
      end
   end

   // every accepted response transaction is matched against the oldest prediction
   always @(posedge clock) begin : range_checker
      range_result_type wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_ranges.size() == 0) begin
            check_failures++;
            if (check_failures <= MAX_REPORTS) begin
               $display("%0t: unexpected range begin=%0d end=%0d valid=%0b last=%0b",
                        $realtime, rsp_bus.range_begin, rsp_bus.range_end,
                        rsp_bus.range_valid, rsp_bus.last);
            end
         end else begin
            wanted = expected_ranges.pop_front();
            if (rsp_bus.range_begin !== wanted.range_begin ||
                rsp_bus.range_end !== wanted.range_end ||
                rsp_bus.range_valid !== wanted.range_valid ||
                rsp_bus.last !== wanted.last) begin
               check_failures++;
               if (check_failures <= MAX_REPORTS) begin
                  $display("%0t: range mismatch expected begin=%0d end=%0d valid=%0b last=%0b",
                           $realtime, wanted.range_begin, wanted.range_end,
                           wanted.range_valid, wanted.last);
                  $display("%0t:                  actual begin=%0d end=%0d valid=%0b last=%0b",
                           $realtime, rsp_bus.range_begin, rsp_bus.range_end,
                           rsp_bus.range_valid, rsp_bus.last);
               end
            end
         end
      end
   end

   // response side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !(idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // drives one column transaction and returns at the edge that takes it
   task automatic send_column(pos_type pos, logic rgap, logic qgap, logic eos);
      while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
         // gap on the request side, with junk on the payload
         req_bus.valid    <= 1'b0;
         req_bus.position <= pos_type'($urandom);
         req_bus.ref_gap  <= logic'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.position        <= pos;
      req_bus.ref_gap         <= rgap;
      req_bus.query_gap       <= qgap;
      req_bus.end_of_sequence <= eos;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // stops sending until every predicted range has been read back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      // an edge first so the last accepted column has been through the tracker
      @(posedge clock);
      while (expected_ranges.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // one well-formed alignment: plain columns with runs of indels, then the end
   task automatic send_alignment(int columns, pos_type base);
      pos_type pos;
      int      sent;
      int      roll;
      int      run_len;
      logic    is_insertion;
      pos  = base;
      sent = 0;
      while (sent < columns) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            send_column(pos, 1'b0, 1'b0, 1'b0);
            pos++;
            sent++;
         end else begin
            run_len      = $urandom_range(1, 4);
            is_insertion = logic'($urandom_range(0, 1));
            repeat (run_len) begin
               // query_gap rides along on insertions, where it has no effect
               send_column(pos, is_insertion,
                           is_insertion ? logic'($urandom_range(0, 1)) : 1'b1, 1'b0);
               pos++;
               sent++;
            end
         end
         // now and then jump ahead so indel runs are not adjacent
         if (roll >= 95) begin
            pos += pos_type'($urandom_range(2, 20));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         pos = pos_type'($urandom);
      end
      send_column(pos, logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), 1'b1);
   endtask

   function automatic pos_type pick_base();
      if ($urandom_range(0, 4) == 0) begin
         return pos_type'($urandom);
      end
      return '0;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   task automatic test_directed_corners();
      // end with nothing open: empty range, marked last
      send_column('0, 1'b0, 1'b0, 1'b1);
      // first indel at column 1 with the last indel still unset
      send_column(pos_type'(1), 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(2), 1'b0, 1'b0, 1'b0);
      send_column(pos_type'(3), 1'b1, 1'b0, 1'b0);
      // plain column with frame back at 0 reports [2,3)
      send_column(pos_type'(4), 1'b0, 1'b0, 1'b0);
      // unset again after the report: column 1 is not adjacent to column 0
      send_column(pos_type'(1), 1'b1, 1'b1, 1'b0);
      send_column(pos_type'(5), 1'b0, 1'b0, 1'b0);
      send_column(pos_type'(6), 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(7), 1'b0, 1'b0, 1'b0);
      send_column('0, 1'b0, 1'b0, 1'b1);
      // indel at the top column, next indel at 0 is not adjacent
      send_column('1, 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(100), 1'b0, 1'b0, 1'b0);
      send_column('0, 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(1), 1'b0, 1'b1, 1'b0);
      // positions out of order: begin above end
      send_column(pos_type'(2), 1'b0, 1'b0, 1'b0);
      // open range closed by an end carrying both gap flags
      send_column(pos_type'(10), 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(11), 1'b0, 1'b0, 1'b0);
      send_column('1, 1'b1, 1'b1, 1'b1);
      // open range closed at length 0, top column opens it
      send_column(pos_type'(20), 1'b1, 1'b0, 1'b0);
      send_column('1, 1'b0, 1'b0, 1'b0);
      send_column('0, 1'b0, 1'b0, 1'b1);
      // frame 1 to 2 needs no recheck
      send_column(pos_type'(30), 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(31), 1'b0, 1'b0, 1'b0);
      send_column(pos_type'(40), 1'b0, 1'b1, 1'b0);
      send_column(pos_type'(41), 1'b0, 1'b0, 1'b0);
      send_column(pos_type'(42), 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_random_alignments(int count);
      repeat (count) begin
         send_alignment($urandom_range(4, 24), pick_base());
      end
   endtask

   task automatic test_back_to_back(int count);
      // long stretch with no idling on either side
      idle_enabled = 1'b0;
      repeat (count) begin
         send_alignment($urandom_range(4, 24), pick_base());
      end
      idle_enabled = 1'b1;
   endtask

   task automatic test_drain_pause(int count);
      repeat (count) begin
         send_alignment($urandom_range(4, 24), pick_base());
         send_column(pos_type'($urandom_range(0, 9)), 1'b0, 1'b1, 1'b0);
         send_column(pos_type'($urandom_range(10, 19)), 1'b0, 1'b0, 1'b0);
         // hold the sender mid-sequence until every range has come back
         wait_for_drain();
      end
   endtask

   task automatic test_noise(int count);
      repeat (count) begin
         send_column(pos_type'($urandom), $urandom_range(0, 99) < 20,
                     $urandom_range(0, 99) < 25, $urandom_range(0, 99) < 5);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      clear_frame_state();
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.position        <= '0;
      req_bus.ref_gap         <= 1'b0;
      req_bus.query_gap       <= 1'b0;
      req_bus.end_of_sequence <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_alignments(50);
      test_back_to_back(20);
      test_drain_pause(8);
      test_noise(300);
      test_random_alignments(5);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (check_failures == 0 && expected_ranges.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
